/* sv/tlvsd_pkg.sv */
// Shared types and constants for the TLV stream deframer.
`timescale 1ns / 1ps

package tlvsd_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned HALF_BYTES   = HEADER_BYTES / 2;
  localparam int unsigned HDR_CNT_W    = $clog2(HEADER_BYTES);

  localparam int unsigned MAX_LEN_W    = 31;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'd65535;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_LEN_ERR = 1'b1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] message_type;
    logic        byte_valid;
    logic        last_of_message;
    logic        status;
  } res_t;

endpackage

/* sv/tlv_stream_deframer_top.sv */
// Top level of the TLV stream deframer: header parse, payload tagging, output skid.
`timescale 1ns / 1ps

// Channel   Valid/Ready              Payload
// -------   ----------------------   ----------------------------------------------
// input     in_valid_i/in_ready_o    stream_byte_i
// output    out_valid_o/out_ready_i  payload_byte_o, message_type_o, byte_valid_o,
//                                    last_of_message_o, status_o
// config    cfg_we_i (no wait)       cfg_wdata_i (max payload length)
//
// One byte per clock while in_ready_o is high; results are registered after the
// parse logic, in the output register or, while it is held, in the skid entry.
// Reset clears the parser to header hunting and the max length to 65535.
// An output register plus one skid entry decouple the sides: input stalls
// only when both hold a waiting result.

module tlv_stream_deframer_top
  import tlvsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           stream_byte_i,
  input  logic                 cfg_we_i,
  input  logic [MAX_LEN_W-1:0] cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           payload_byte_o,
  output logic [31:0]          message_type_o,
  output logic                 byte_valid_o,
  output logic                 last_of_message_o,
  output logic                 status_o
);

  logic [MAX_LEN_W-1:0] max_len_q;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [31:0]          len_q, len_d;
  logic [31:0]          type_q, type_d;
  logic [31:0]          rem_q, rem_d;
  logic                 in_pay_q, in_pay_d;

  res_t                 out_q, skid_q, res;
  logic                 out_vld_q, skid_vld_q;
  logic                 res_vld;
  logic                 in_acc, out_acc;
  logic [31:0]          type_full;
  logic                 pay_last;

  assign in_ready_o = !skid_vld_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_vld_q && out_ready_i;

  assign type_full = {stream_byte_i, type_q[31:8]};
  assign pay_last  = (rem_q <= 32'd1);

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    len_d     = len_q;
    type_d    = type_q;
    rem_d     = rem_q;
    in_pay_d  = in_pay_q;
    res_vld   = 1'b0;
    res       = '0;
    res.message_type = type_q;
    res.status       = STATUS_OK;
    if (in_pay_q) begin
      res_vld              = 1'b1;
      res.payload_byte     = stream_byte_i;
      res.byte_valid       = 1'b1;
      res.last_of_message  = pay_last;
      if (pay_last) begin
        rem_d     = '0;
        in_pay_d  = 1'b0;
        hdr_cnt_d = '0;
      end else begin
        rem_d = rem_q - 32'd1;
      end
    end else begin
      // little-endian: shift each byte in from the top
      if (hdr_cnt_q < HDR_CNT_W'(HALF_BYTES)) begin
        len_d = {stream_byte_i, len_q[31:8]};
      end else begin
        type_d = type_full;
      end
      if (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1)) begin
        hdr_cnt_d            = '0;
        res.message_type     = type_full;
        res.last_of_message  = 1'b1;
        if (len_q > {1'b0, max_len_q}) begin
          res_vld    = 1'b1;
          res.status = STATUS_LEN_ERR;
        end else if (len_q == 32'd0) begin
          res_vld = 1'b1;
        end else begin
          rem_d    = len_q;
          in_pay_d = 1'b1;
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      hdr_cnt_q <= '0;
      len_q     <= '0;
      type_q    <= '0;
      rem_q     <= '0;
      in_pay_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        hdr_cnt_q <= hdr_cnt_d;
        len_q     <= len_d;
        type_q    <= type_d;
        rem_q     <= rem_d;
        in_pay_q  <= in_pay_d;
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_acc) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= in_acc && res_vld;
        end else begin
          out_vld_q <= in_acc && res_vld;
        end
      end else if (in_acc && res_vld) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (in_acc && res_vld) begin
          skid_q <= res;
        end
      end else if (in_acc && res_vld) begin
        out_q <= res;
      end
    end else if (in_acc && res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign payload_byte_o    = out_q.payload_byte;
  assign message_type_o    = out_q.message_type;
  assign byte_valid_o      = out_q.byte_valid;
  assign last_of_message_o = out_q.last_of_message;
  assign status_o          = out_q.status;

endmodule
